// ----- hdl/yuyv422_to_rgb24_assert.svh -----
// ----------------------------------------------------------------------------
// yuyv422_to_rgb24 assertion macros
// implication checks on the block clock, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef YUYV422_TO_RGB24_ASSERT_SVH
`define YUYV422_TO_RGB24_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define Y2R_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("y2r assertion failed");
// next-cycle implication
`define Y2R_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("y2r assertion failed");
`else
`define Y2R_ASSERT_IMP(name, ante, cons)
`define Y2R_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ----- hdl/y2r_pkg.sv -----
// ----------------------------------------------------------------------------
// y2r_pkg
// fixed widths, pixel type and bt.601 coefficient ratios for yuyv422_to_rgb24
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int PIX_W = 8;
  localparam int IN_W  = 4 * PIX_W;
  localparam int OUT_W = 3 * PIX_W;

  // coefficients as exact decimal ratios, scaled and rounded half up in the rtl
  localparam longint CR_R_NUM = 1402;
  localparam longint CR_R_DEN = 1000;
  localparam longint CB_G_NUM = 34414;
  localparam longint CB_G_DEN = 100000;
  localparam longint CR_G_NUM = 71414;
  localparam longint CR_G_DEN = 100000;
  localparam longint CB_B_NUM = 1772;
  localparam longint CB_B_DEN = 1000;

  // red in the lowest bits
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

endpackage

// ----- hdl/yuyv422_to_rgb24.sv -----
// ----------------------------------------------------------------------------
// yuyv422_to_rgb24
// yuyv 4:2:2 macropixel to two rgb888 pixels, full-range bt.601
// ----------------------------------------------------------------------------
// path: a macropixel passes the input register, three arithmetic stages and the
//   output register; the second pixel of the pair follows the first on the bus
// throughput: set by the output port carrying one pixel per beat; the input
//   side takes a beat every cycle while stages have room
// reset: rst clears all valid bits and the output phase, payload is not reset
`include "yuyv422_to_rgb24_assert.svh"

module yuyv422_to_rgb24 #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // y_first [7:0], cb [15:8], y_second [23:16], cr [31:24]
  input  logic [y2r_pkg::IN_W-1:0]   s_axis_tdata,
  // frame_end_in
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [y2r_pkg::OUT_W-1:0]  m_axis_tdata,
  // pair_last
  output logic                       m_axis_tuser,
  // frame_done
  output logic                       m_axis_tlast
);

  import y2r_pkg::*;

  localparam int F  = COEF_FRAC_BITS;
  localparam int CW = F + 2;         // signed coefficient width
  localparam int PW = F + 11;        // signed 9 x CW product
  localparam int SW = F + 12;        // signed channel sum

  localparam longint FRAC_ONE = longint'(1) << F;
  localparam longint K_CR_R_L = (CR_R_NUM * FRAC_ONE + CR_R_DEN / 2) / CR_R_DEN;
  localparam longint K_CB_G_L = (CB_G_NUM * FRAC_ONE + CB_G_DEN / 2) / CB_G_DEN;
  localparam longint K_CR_G_L = (CR_G_NUM * FRAC_ONE + CR_G_DEN / 2) / CR_G_DEN;
  localparam longint K_CB_B_L = (CB_B_NUM * FRAC_ONE + CB_B_DEN / 2) / CB_B_DEN;

  localparam logic signed [CW-1:0] K_CR_R = CW'(K_CR_R_L);
  localparam logic signed [CW-1:0] K_CB_G = CW'(K_CB_G_L);
  localparam logic signed [CW-1:0] K_CR_G = CW'(K_CR_G_L);
  localparam logic signed [CW-1:0] K_CB_B = CW'(K_CB_B_L);

  // drop the fraction, then saturate to 0..255
  function automatic logic [PIX_W-1:0] clamp8(input logic signed [SW-1:0] s);
    if (s[SW-1]) begin
      return '0;
    end else if (|s[SW-2:F+PIX_W]) begin
      return '1;
    end else begin
      return s[F+PIX_W-1:F];
    end
  endfunction

  // stage 1: input register, chroma offsets removed
  logic                     v1;
  logic [PIX_W-1:0]         y0_1, y1_1;
  logic signed [PIX_W:0]    dcb_1, dcr_1;
  logic                     fe_1;

  // stage 2: the four chroma products
  logic                     v2;
  logic [PIX_W-1:0]         y0_2, y1_2;
  logic signed [PW-1:0]     p_rr, p_gb, p_gr, p_bb;
  logic                     fe_2;

  // stage 3: channel sums for both pixels
  logic                     v3;
  logic signed [SW-1:0]     s_r0, s_g0, s_b0, s_r1, s_g1, s_b1;
  logic                     fe_3;

  // stage 4: clamped pixel pair
  logic                     v4;
  rgb_t                     pix0_4, pix1_4;
  logic                     fe_4;

  // output register, phase picks the pixel of the pair on the bus
  logic                     ov;
  logic                     phase;
  rgb_t                     pix0_o, pix1_o;
  logic                     fe_o;

  // stage load enables, a stage takes data when empty or when it moves on
  logic                     load_o, go4, go3, go2, go1;

  // luma moved to the coefficient scale
  logic signed [SW-1:0]     ys0, ys1;

  assign load_o = !ov || (phase && m_axis_tready);
  assign go4    = !v4 || load_o;
  assign go3    = !v3 || go4;
  assign go2    = !v2 || go3;
  assign go1    = !v1 || go2;

  assign s_axis_tready = go1;

  assign ys0 = signed'({{(SW-PIX_W-F){1'b0}}, y0_2, {F{1'b0}}});
  assign ys1 = signed'({{(SW-PIX_W-F){1'b0}}, y1_2, {F{1'b0}}});

  // valid bits and output phase
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      ov    <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (go1) begin
        v1 <= s_axis_tvalid;
      end
      if (go2) begin
        v2 <= v1;
      end
      if (go3) begin
        v3 <= v2;
      end
      if (go4) begin
        v4 <= v3;
      end
      if (load_o) begin
        ov    <= v4;
        phase <= 1'b0;
      end else if (m_axis_tready && !phase) begin
        // first pixel taken, second goes on the bus
        phase <= 1'b1;
      end
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (go1) begin
      y0_1  <= s_axis_tdata[PIX_W-1:0];
      y1_1  <= s_axis_tdata[3*PIX_W-1:2*PIX_W];
      // byte - 128 is the byte with its top bit flipped, read as signed
      dcb_1 <= signed'({~s_axis_tdata[2*PIX_W-1], ~s_axis_tdata[2*PIX_W-1],
                        s_axis_tdata[2*PIX_W-2:PIX_W]});
      dcr_1 <= signed'({~s_axis_tdata[4*PIX_W-1], ~s_axis_tdata[4*PIX_W-1],
                        s_axis_tdata[4*PIX_W-2:3*PIX_W]});
      fe_1  <= s_axis_tlast;
    end
    if (go2) begin
      y0_2 <= y0_1;
      y1_2 <= y1_1;
      p_rr <= PW'(dcr_1) * PW'(K_CR_R);
      p_gb <= PW'(dcb_1) * PW'(K_CB_G);
      p_gr <= PW'(dcr_1) * PW'(K_CR_G);
      p_bb <= PW'(dcb_1) * PW'(K_CB_B);
      fe_2 <= fe_1;
    end
    if (go3) begin
      s_r0 <= ys0 + SW'(p_rr);
      s_g0 <= ys0 - SW'(p_gb) - SW'(p_gr);
      s_b0 <= ys0 + SW'(p_bb);
      s_r1 <= ys1 + SW'(p_rr);
      s_g1 <= ys1 - SW'(p_gb) - SW'(p_gr);
      s_b1 <= ys1 + SW'(p_bb);
      fe_3 <= fe_2;
    end
    if (go4) begin
      pix0_4.red   <= clamp8(s_r0);
      pix0_4.green <= clamp8(s_g0);
      pix0_4.blue  <= clamp8(s_b0);
      pix1_4.red   <= clamp8(s_r1);
      pix1_4.green <= clamp8(s_g1);
      pix1_4.blue  <= clamp8(s_b1);
      fe_4         <= fe_3;
    end
    if (load_o) begin
      pix0_o <= pix0_4;
      pix1_o <= pix1_4;
      fe_o   <= fe_4;
    end
  end

  // output bus, second beat carries the pair and frame marks
  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = phase ? pix1_o : pix0_o;
  assign m_axis_tuser  = phase;
  assign m_axis_tlast  = phase && fe_o;

  // a first-pixel beat is always followed by the second pixel of its pair
  `Y2R_ASSERT_NXT(a_pair_order, m_axis_tvalid && m_axis_tready && !m_axis_tuser,
                  m_axis_tvalid && m_axis_tuser)
  // input backpressure only when every stage holds an item
  `Y2R_ASSERT_IMP(a_stall_full, !s_axis_tready, v1 && v2 && v3 && v4 && ov)
  // a pair moved into the output register starts with its first pixel
  `Y2R_ASSERT_NXT(a_load_first, v4 && load_o, m_axis_tvalid && !m_axis_tuser)

endmodule

// ----- dv/yuyv422_to_rgb24_checker.sv -----
// ----------------------------------------------------------------------------
// yuyv422_to_rgb24_checker
// watches both stream ports, predicts two rgb pixels per macropixel beat and
// compares every output beat in order
// ----------------------------------------------------------------------------
module yuyv422_to_rgb24_checker #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [y2r_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic                      s_axis_tlast,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [y2r_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                      m_axis_tuser,
  input  logic                      m_axis_tlast,
  output int                        err_count,
  output int                        pending,
  output int                        pix_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = longint'(1) << COEF_FRAC_BITS;
  localparam longint K_CR_R =
    (y2r_pkg::CR_R_NUM * ONE + y2r_pkg::CR_R_DEN / 2) / y2r_pkg::CR_R_DEN;
  localparam longint K_CB_G =
    (y2r_pkg::CB_G_NUM * ONE + y2r_pkg::CB_G_DEN / 2) / y2r_pkg::CB_G_DEN;
  localparam longint K_CR_G =
    (y2r_pkg::CR_G_NUM * ONE + y2r_pkg::CR_G_DEN / 2) / y2r_pkg::CR_G_DEN;
  localparam longint K_CB_B =
    (y2r_pkg::CB_B_NUM * ONE + y2r_pkg::CB_B_DEN / 2) / y2r_pkg::CB_B_DEN;

  typedef struct packed {
    y2r_pkg::rgb_t color;
    logic          pair_last;
    logic          frame_done;
  } pixel_t;

  pixel_t expected_px[$];

  // drop the fraction, saturate to one byte
  function automatic logic [7:0] sat_channel(input longint acc);
    longint whole;
    if (acc < 0) return 8'd0;
    whole = acc >>> COEF_FRAC_BITS;
    if (whole > 255) return 8'd255;
    return whole[7:0];
  endfunction

  function automatic pixel_t predict_pixel(input logic [7:0] luma, input longint dcb,
                                           input longint dcr, input logic pl,
                                           input logic fd);
    pixel_t px;
    longint ys;
    ys = longint'(luma) * ONE;
    px.color.red   = sat_channel(ys + K_CR_R * dcr);
    px.color.green = sat_channel(ys - K_CB_G * dcb - K_CR_G * dcr);
    px.color.blue  = sat_channel(ys + K_CB_B * dcb);
    px.pair_last   = pl;
    px.frame_done  = fd;
    return px;
  endfunction

  task automatic check_field(input string name, input int want, input int got,
                             inout int bad);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      bad++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    longint dcb;
    longint dcr;
    int     bad;
    if (rst) begin
      err_count   <= 0;
      pending     <= 0;
      pix_checked <= 0;
      expected_px.delete();
    end else begin
      bad = 0;
      // check output first so a same-edge input beat cannot hide a stray pixel
      if (m_axis_tvalid && m_axis_tready) begin
        got.color      = m_axis_tdata;
        got.pair_last  = m_axis_tuser;
        got.frame_done = m_axis_tlast;
        if (expected_px.size() == 0) begin
          $error("pixel beat with no prediction waiting: tdata %h", m_axis_tdata);
          bad++;
        end else begin
          want = expected_px.pop_front();
          check_field("red", int'(want.color.red), int'(got.color.red), bad);
          check_field("green", int'(want.color.green), int'(got.color.green), bad);
          check_field("blue", int'(want.color.blue), int'(got.color.blue), bad);
          check_field("pair_last", int'(want.pair_last), int'(got.pair_last), bad);
          check_field("frame_done", int'(want.frame_done), int'(got.frame_done), bad);
        end
        pix_checked <= pix_checked + 1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        dcb = longint'(s_axis_tdata[15:8]) - 128;
        dcr = longint'(s_axis_tdata[31:24]) - 128;
        expected_px.push_back(predict_pixel(s_axis_tdata[7:0], dcb, dcr, 1'b0, 1'b0));
        expected_px.push_back(predict_pixel(s_axis_tdata[23:16], dcb, dcr, 1'b1,
                                            s_axis_tlast));
      end
      err_count <= err_count + bad;
      pending   <= expected_px.size();
    end
  end

endmodule

// ----- dv/tb_yuyv422_to_rgb24.sv -----
// ----------------------------------------------------------------------------
// tb_yuyv422_to_rgb24
// stream testbench: corner macropixels, then framed random traffic under three
// idle mixes and long output stalls; checking lives in the checker module
// ----------------------------------------------------------------------------
module tb_yuyv422_to_rgb24;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_MIX = 580;
  localparam int HOLD_CYCLES   = 120;
  localparam int WATCHDOG_MAX  = 3000;
  localparam int DRAIN_CYCLES  = 20;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [y2r_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                      s_axis_tlast = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [y2r_pkg::OUT_W-1:0] m_axis_tdata;
  logic                      m_axis_tuser;
  logic                      m_axis_tlast;

  int err_count;
  int pending;
  int pix_checked;

  // idle odds in percent, set per mix by the stimulus
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  // stimulus raises this, the output side clears it once the stall is served
  logic hold_off_req = 1'b0;
  int   hold_offs    = 0;
  int   mp_sent      = 0;
  int   frames_sent  = 0;
  int   quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  yuyv422_to_rgb24 u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  yuyv422_to_rgb24_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .err_count     (err_count),
    .pending       (pending),
    .pix_checked   (pix_checked)
  );

  // output side: random ready, or a long hold-off counted here when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        hold_offs++;
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog: too long without any beat on either port
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("yuyv422_to_rgb24 verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one macropixel beat, with random idle cycles ahead of it
  task automatic send_mp(input logic [7:0] y0, input logic [7:0] cb,
                         input logic [7:0] y1, input logic [7:0] cr,
                         input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom();
      s_axis_tlast  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cr, y1, cb, y0};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    mp_sent++;
    if (last) frames_sent++;
  endtask

  // mostly uniform bytes, sometimes near the clamp and offset edges
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(7) != 0) return 8'($urandom_range(255));
    case ($urandom_range(6))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd129;
      5: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // frames of random length, a few long ones, some stray one-beat frames
  task automatic send_frames(input int count);
    int done;
    int flen;
    done = 0;
    while (done < count) begin
      flen = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      for (int i = 0; i < flen && done < count; i++) begin
        if ($urandom_range(19) == 0)
          send_mp(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                  1'($urandom_range(1)));
        else
          send_mp(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                  (i == flen - 1) || (done == count - 1));
        done++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners under light idling
    src_idle_pct = 20;
    snk_idle_pct = 20;
    send_mp(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);          // red and blue below zero
    send_mp(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);  // red and blue above 255
    send_mp(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);      // mixed clamp, ends a three-beat frame
    send_mp(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    send_mp(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);  // neutral chroma, gray
    send_mp(8'd0, 8'd128, 8'd255, 8'd128, 1'b0);    // luma extremes pass through
    send_mp(8'd1, 8'd129, 8'd1, 8'd129, 1'b0);      // green just below zero
    send_mp(8'd2, 8'd129, 8'd3, 8'd129, 1'b0);
    send_mp(8'd254, 8'd127, 8'd255, 8'd127, 1'b0);  // green just over 255
    send_mp(8'd200, 8'd200, 8'd50, 8'd60, 1'b0);
    send_mp(8'd16, 8'd240, 8'd235, 8'd16, 1'b0);
    send_mp(8'd100, 8'd1, 8'd101, 8'd254, 1'b0);
    send_mp(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);      // alternating bit patterns
    send_mp(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1);
    send_mp(8'd128, 8'd0, 8'd128, 8'd255, 1'b1);    // back-to-back frame ends

    // sender idles less than the receiver, with one long output stall
    src_idle_pct = 20;
    snk_idle_pct = 56;
    hold_off_req = 1'b1;
    send_frames(ITEMS_PER_MIX);

    // receiver idles less than the sender
    src_idle_pct = 56;
    snk_idle_pct = 20;
    send_frames(ITEMS_PER_MIX);

    // full rate on both sides, then a stall so the pipeline backs up
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_frames(ITEMS_PER_MIX / 2);
    hold_off_req = 1'b1;
    send_frames(ITEMS_PER_MIX / 2);
    s_axis_tvalid <= 1'b0;

    while (pending != 0 || hold_off_req) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d macropixels in %0d frames, %0d pixel beats checked",
             mp_sent, frames_sent, pix_checked);
    $display("three idle mixes, %0d long output stalls, clamp and truncation corners",
             hold_offs);
    if (err_count == 0) begin
      $display("yuyv422_to_rgb24 verification clean");
    end else begin
      $display("yuyv422_to_rgb24 verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/y2r_pkg.sv
hdl/yuyv422_to_rgb24.sv
dv/yuyv422_to_rgb24_checker.sv
dv/tb_yuyv422_to_rgb24.sv
